// ===== sv/ehbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Extended Hamming block decoder package
// Shared constants, status codes and the store control bundle.
// ----------------------------------------------------------------------------
package ehbd_pkg;

  // Largest supported block is 2^MaxLogBits bits.
  localparam int unsigned MaxLogBits = 8;
  localparam int unsigned MinLogBits = 3;
  localparam int unsigned AddrW      = MaxLogBits - 3;      // byte address
  localparam int unsigned StoreDepth = 1 << AddrW;
  localparam int unsigned PosW       = MaxLogBits + 1;      // bit position, holds 2^L
  localparam int unsigned SynW       = MaxLogBits;          // syndrome width
  localparam int unsigned LogW       = 4;                   // register width

  typedef enum logic [1:0] {
    ST_CLEAN     = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_UNCORR    = 2'd2
  } status_e;

  // Control of the block store and its serial byte register.
  typedef struct packed {
    logic wr_en;     // write a request byte and load it for serial scan
    logic rd_en;     // read a stored byte into the serial register
    logic shift_en;  // move the serial register on by one bit
  } store_ctrl_t;

  // Clamp the configured log size into the supported range.
  function automatic logic [LogW-1:0] eff_log(input logic [LogW-1:0] l);
    logic [LogW-1:0] r;
    r = l;
    if (l < LogW'(MinLogBits)) begin
      r = LogW'(MinLogBits);
    end else if (l > LogW'(MaxLogBits)) begin
      r = LogW'(MaxLogBits);
    end
    return r;
  endfunction

endpackage

// ===== sv/ehbd_store.sv =====
// ----------------------------------------------------------------------------
// Extended Hamming block store
// Byte memory of one code block with a serial byte register that presents
// one bit per cycle while shift_en is set, most significant bit first.
// ----------------------------------------------------------------------------
module ehbd_store (
  input  logic                      clk_i,
  input  ehbd_pkg::store_ctrl_t     ctrl_i,
  input  logic [ehbd_pkg::AddrW-1:0] addr_i,
  input  logic [7:0]                wdata_i,
  output logic                      bit_o
);
  import ehbd_pkg::*;

  logic [7:0] mem [StoreDepth];
  logic [7:0] sh_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // The serial register takes a fresh byte on a write or a read, else shifts.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      sh_q <= wdata_i;
    end else if (ctrl_i.rd_en) begin
      sh_q <= mem[addr_i];
    end else if (ctrl_i.shift_en) begin
      sh_q <= {sh_q[6:0], 1'b0};
    end
  end

  assign bit_o = sh_q[7];

endmodule

// ===== sv/extended_hamming_block_decoder.sv =====
// ----------------------------------------------------------------------------
// Extended Hamming block decoder
// Single-error-correcting, double-error-detecting decoder for code blocks of
// 2^L bits, delivered as bytes and returned as packed data chunks.
// ----------------------------------------------------------------------------
// A code block of 2^L bits (L from cfg_wdata_i, clamped to 3..8, reset 8)
// arrives as 2^(L-3) byte requests, bit position 0 in bit 7 of the first
// byte. Each byte is written to the block store and then scanned one bit per
// cycle; no further byte is accepted until the serial scan has folded the
// positions of its one bits into the syndrome and the overall parity.
// After the last byte the classify state judges the block. A clean block
// and a block with a single error are then read back from the store one
// byte at a time (a read state, then a bit state for each of its bits),
// the erroneous bit being inverted on the fly, and every data bit
// (positions 3 and up that are not powers of two) is packed into chunks
// of up to eight bits, first bit in bit 7. An uncorrectable block gives
// one result with status 2, no data and tlast set. The extraction scan
// pauses whenever the output register holds a result that the sink has
// not taken. No new byte is taken while a block is being emitted. A write
// to the configuration register drops any partly received block.
// ----------------------------------------------------------------------------
module extended_hamming_block_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration: block log size
  input  logic                          cfg_we_i,
  input  logic [ehbd_pkg::LogW-1:0]     cfg_wdata_i,
  // Byte input
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  // Chunk output
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,  // [7:0] data_chunk,
                                                       // [11:8] chunk_bits,
                                                       // [15:12] zero
  output logic [1:0]                    m_axis_tuser,  // [1:0] status
  output logic                          m_axis_tlast   // last result of the block
);
  import ehbd_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IN    = 3'd0;  // waiting for a byte request
  localparam logic [2:0] S_ACC   = 3'd1;  // serial syndrome scan of one byte
  localparam logic [2:0] S_CLASS = 3'd2;  // classify the finished block
  localparam logic [2:0] S_RD    = 3'd3;  // read a stored byte
  localparam logic [2:0] S_BIT   = 3'd4;  // serial data extraction
  localparam logic [2:0] S_ERR   = 3'd5;  // report an uncorrectable block

  logic [2:0]      state_q, state_d;
  logic [LogW-1:0] log_q, log_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [SynW-1:0] syn_q, syn_d;
  logic            par_q, par_d;
  status_e         status_q, status_d;
  logic [7:0]      chunk_q, chunk_d;
  logic [3:0]      cnt_q, cnt_d;

  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_chunk_q, out_chunk_d;
  logic [3:0]      out_bits_q, out_bits_d;
  status_e         out_status_q, out_status_d;
  logic            out_last_q, out_last_d;

  store_ctrl_t     store_ctrl;
  logic            store_bit;

  logic [PosW-1:0] nbits_m1;
  logic [PosW-1:0] pos_dec;
  logic            last_pos;
  logic            take;
  logic            data_bit;
  logic            advance;
  logic [3:0]      cnt_next;
  logic [7:0]      chunk_next;

  ehbd_store u_store (
    .clk_i  (clk_i),
    .ctrl_i (store_ctrl),
    .addr_i (pos_q[AddrW+2:3]),
    .wdata_i(s_axis_tdata),
    .bit_o  (store_bit)
  );

  // Highest bit position of the current block size.
  assign nbits_m1 = (PosW'(1) << eff_log(log_q)) - PosW'(1);
  assign last_pos = (pos_q == nbits_m1);
  assign pos_dec  = pos_q - PosW'(1);

  // Data bits are positions 3 and up that are not powers of two.
  assign take = (pos_q >= PosW'(3)) && ((pos_q & pos_dec) != '0);

  // The erroneous bit, if any, is inverted as it passes.
  assign data_bit = store_bit ^ ((status_q == ST_CORRECTED) &&
                                 (pos_q[SynW-1:0] == (syn_q & nbits_m1[SynW-1:0])));

  assign cnt_next   = cnt_q + {3'b000, take};
  assign chunk_next = take ? (chunk_q | ({7'b0, data_bit} << (3'd7 - cnt_q[2:0])))
                           : chunk_q;

  // A step that may produce a result only runs when the output slot is free.
  assign advance = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == S_IN);

  always_comb begin
    state_d      = state_q;
    log_d        = log_q;
    pos_d        = pos_q;
    syn_d        = syn_q;
    par_d        = par_q;
    status_d     = status_q;
    chunk_d      = chunk_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_chunk_d  = out_chunk_q;
    out_bits_d   = out_bits_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    store_ctrl   = '0;

    unique case (state_q)
      S_IN: begin
        if (s_axis_tvalid) begin
          store_ctrl.wr_en = 1'b1;
          state_d          = S_ACC;
        end
      end
      S_ACC: begin
        store_ctrl.shift_en = 1'b1;
        if (store_bit) begin
          syn_d = syn_q ^ pos_q[SynW-1:0];
          par_d = ~par_q;
        end
        pos_d = pos_q + PosW'(1);
        if (last_pos) begin
          state_d = S_CLASS;
        end else if (pos_q[2:0] == 3'd7) begin
          state_d = S_IN;
        end
      end
      S_CLASS: begin
        pos_d   = '0;
        chunk_d = '0;
        cnt_d   = '0;
        if (par_q) begin
          status_d = ST_CORRECTED;
          state_d  = S_RD;
        end else if (syn_q == '0) begin
          status_d = ST_CLEAN;
          state_d  = S_RD;
        end else begin
          status_d = ST_UNCORR;
          state_d  = S_ERR;
        end
      end
      S_RD: begin
        store_ctrl.rd_en = 1'b1;
        state_d          = S_BIT;
      end
      S_BIT: begin
        if (advance) begin
          store_ctrl.shift_en = 1'b1;
          chunk_d             = chunk_next;
          cnt_d               = cnt_next;
          if ((cnt_next == 4'd8) || (last_pos && (cnt_next != 4'd0))) begin
            out_valid_d  = 1'b1;
            out_chunk_d  = chunk_next;
            out_bits_d   = cnt_next;
            out_status_d = status_q;
            out_last_d   = last_pos;
            chunk_d      = '0;
            cnt_d        = '0;
          end
          pos_d = pos_q + PosW'(1);
          if (last_pos) begin
            pos_d   = '0;
            syn_d   = '0;
            par_d   = 1'b0;
            state_d = S_IN;
          end else if (pos_q[2:0] == 3'd7) begin
            state_d = S_RD;
          end
        end
      end
      S_ERR: begin
        if (advance) begin
          out_valid_d  = 1'b1;
          out_chunk_d  = '0;
          out_bits_d   = '0;
          out_status_d = ST_UNCORR;
          out_last_d   = 1'b1;
          pos_d        = '0;
          syn_d        = '0;
          par_d        = 1'b0;
          state_d      = S_IN;
        end
      end
      default: begin
        state_d = S_IN;
      end
    endcase

    // A configuration write drops the block in progress.
    if (cfg_we_i) begin
      log_d   = cfg_wdata_i;
      pos_d   = '0;
      syn_d   = '0;
      par_d   = 1'b0;
      state_d = S_IN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IN;
      log_q       <= LogW'(MaxLogBits);
      pos_q       <= '0;
      syn_q       <= '0;
      par_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      log_q       <= log_d;
      pos_q       <= pos_d;
      syn_q       <= syn_d;
      par_q       <= par_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    chunk_q      <= chunk_d;
    cnt_q        <= cnt_d;
    out_chunk_q  <= out_chunk_d;
    out_bits_q   <= out_bits_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_bits_q, out_chunk_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

endmodule
